/* design/vrt_pkg.sv */
// Shared constants, command and status types for the voxel ray traversal unit.
`timescale 1ns / 1ps

package vrt_pkg;

	localparam int FRAC_BITS      = 8;
	localparam int INT_BITS       = 8;
	localparam int IN_W           = INT_BITS + FRAC_BITS;
	localparam int REG_W          = INT_BITS + 1;
	localparam int VOX_W          = INT_BITS;
	localparam int MAX_VOXELS_DEF = 64;

	localparam int IN_DATA_W  = 6 * IN_W;
	localparam int OUT_DATA_W = 3 * VOX_W;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 3;

	// Voxel index, per-axis span, first crossing numerator.
	localparam int IDX_W  = INT_BITS + 1;
	localparam int SPAN_W = INT_BITS;
	localparam int NUM_W  = FRAC_BITS + 1;
	// Crossing numerator times a span of another axis.
	localparam int P_W    = FRAC_BITS + 2 * INT_BITS + 1;
	// Corner offset, its square and sums of three squares.
	localparam int Q_W    = IN_W + 2;
	localparam int SQ_W   = 2 * (IN_W + 1) + 1;
	localparam int MUL_W  = IN_W + 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

	localparam int MUL_SEL_W = 4;
	localparam logic [MUL_SEL_W-1:0] MUL_LEN_X = 4'd0;
	localparam logic [MUL_SEL_W-1:0] MUL_LEN_Y = 4'd1;
	localparam logic [MUL_SEL_W-1:0] MUL_LEN_Z = 4'd2;
	localparam logic [MUL_SEL_W-1:0] MUL_SQ_X  = 4'd3;
	localparam logic [MUL_SEL_W-1:0] MUL_SQ_Y  = 4'd4;
	localparam logic [MUL_SEL_W-1:0] MUL_SQ_Z  = 4'd5;
	localparam logic [MUL_SEL_W-1:0] MUL_P01   = 4'd6;
	localparam logic [MUL_SEL_W-1:0] MUL_P10   = 4'd7;
	localparam logic [MUL_SEL_W-1:0] MUL_P02   = 4'd8;
	localparam logic [MUL_SEL_W-1:0] MUL_P20   = 4'd9;
	localparam logic [MUL_SEL_W-1:0] MUL_P12   = 4'd10;
	localparam logic [MUL_SEL_W-1:0] MUL_P21   = 4'd11;
	localparam logic [MUL_SEL_W-1:0] MUL_LAST  = MUL_P21;

	typedef struct packed {
		logic                 capture;
		logic                 mul_en;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic                 walk;
		logic                 finish;
	} vrt_cmd_t;

	typedef struct packed {
		logic degenerate;
		logic inbox;
		logic stop;
		logic out_free;
	} vrt_stat_t;

endpackage

/* design/voxel_ray_traversal_unit.sv */
// Top level of the voxel ray traversal unit.
`timescale 1ns / 1ps

// Walks the integer voxels crossed by a ray with a 3D DDA.
// Input stream (s_*): one beat carries a ray, start and end points in signed
// Q8.8 voxel units. Output stream (m_*): one beat per voxel inside the box, in
// walk order, m_tlast on the final beat of the ray. A ray with no span or no
// voxel inside the box gives one beat with voxel_valid low and m_tlast high.
// Box registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, as the block does not enforce it. A ray
// is accepted only when the previous one is done. Setup captures the ray,
// then forms 12 products on one shared multiplier. Unless the ray has no
// span, the walk steps through the visited voxels, inside or outside the
// box, and the final beat follows. The first voxel enters the output
// register when the second is found; each voxel waits to learn if it is last.
// When m_tready is low the walk holds at the next voxel inside the box and
// resumes when the output register frees; voxels outside the box keep moving.
// Reset clears the control state and sets the box to its full range.
module voxel_ray_traversal_unit #(
	parameter int MAX_VOXELS = vrt_pkg::MAX_VOXELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z
	input  logic [vrt_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// voxel_x, voxel_y, voxel_z
	output logic [vrt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// voxel_valid, truncated
	output logic [vrt_pkg::OUT_USER_W-1:0]    m_tuser,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [vrt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vrt_pkg::REG_W-1:0]         cfg_data
);
	import vrt_pkg::*;

	vrt_cmd_t  cmd;
	vrt_stat_t stat;

	vrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	vrt_datapath #(
		.MAX_VOXELS (MAX_VOXELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

endmodule

/* design/vrt_ctrl.sv */
// Sequencing state machine of the voxel ray traversal unit.
`timescale 1ns / 1ps

module vrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output vrt_pkg::vrt_cmd_t cmd,
	input  vrt_pkg::vrt_stat_t stat
);
	import vrt_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic [MUL_SEL_W-1:0] mcnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = mcnt_q;
		case (state_q)
			ST_IDLE:  cmd.capture = in_valid;
			ST_SETUP: cmd.mul_en  = 1'b1;
			// A voxel inside the box needs room in the output register.
			ST_WALK:  cmd.walk    = !stat.inbox || stat.out_free;
			ST_DONE:  cmd.finish  = stat.out_free;
			default:  cmd         = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
						mcnt_q  <= '0;
					end
				end
				ST_SETUP: begin
					if (mcnt_q == MUL_LAST) begin
						state_q <= stat.degenerate ? ST_DONE : ST_WALK;
					end else begin
						mcnt_q <= mcnt_q + 1'b1;
					end
				end
				ST_WALK: begin
					if (cmd.walk && stat.stop) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_walk_not_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !stat.degenerate)
		else $error("walk entered for a ray with no span");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("final beat issued while output register is busy");
`endif

endmodule

/* design/vrt_datapath.sv */
// Setup, stepping and output datapath of the voxel ray traversal unit.
`timescale 1ns / 1ps

module vrt_datapath #(
	parameter int MAX_VOXELS = vrt_pkg::MAX_VOXELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vrt_pkg::vrt_cmd_t                cmd,
	output vrt_pkg::vrt_stat_t               stat,
	input  logic [vrt_pkg::IN_DATA_W-1:0]    in_data,
	input  logic                             cfg_we,
	input  logic [vrt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vrt_pkg::REG_W-1:0]        cfg_data,
	output logic [vrt_pkg::OUT_DATA_W-1:0]   out_data,
	output logic [vrt_pkg::OUT_USER_W-1:0]   out_user,
	output logic                             out_last,
	output logic                             out_valid,
	input  logic                             out_ready
);
	import vrt_pkg::*;

	localparam int CNT_W = $clog2(MAX_VOXELS + 1);
	localparam logic [REG_W-1:0] BOX_MIN_RST = REG_W'(-(2 ** (INT_BITS - 1)));
	localparam logic [REG_W-1:0] BOX_MAX_RST = REG_W'(2 ** (INT_BITS - 1));
	localparam logic [NUM_W-1:0] ONE_VOX     = NUM_W'(2 ** FRAC_BITS);

	// Box registers.
	logic signed [REG_W-1:0] bmin_q [3];
	logic signed [REG_W-1:0] bmax_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				bmin_q[a] <= BOX_MIN_RST;
				bmax_q[a] <= BOX_MAX_RST;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOX_MIN_X: bmin_q[0] <= cfg_data;
				CFG_BOX_MAX_X: bmax_q[0] <= cfg_data;
				CFG_BOX_MIN_Y: bmin_q[1] <= cfg_data;
				CFG_BOX_MAX_Y: bmax_q[1] <= cfg_data;
				CFG_BOX_MIN_Z: bmin_q[2] <= cfg_data;
				CFG_BOX_MAX_Z: bmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Setup values taken straight from the input beat.
	logic signed [IN_W-1:0]  s_in   [3];
	logic signed [IN_W-1:0]  e_in   [3];
	logic signed [IDX_W-1:0] v_in   [3];
	logic signed [IDX_W-1:0] ev_in  [3];
	logic signed [IDX_W-1:0] d_in   [3];
	logic [FRAC_BITS-1:0]    fr_in  [3];
	logic [SPAN_W-1:0]       span_in[3];
	logic [NUM_W-1:0]        num_in [3];
	logic signed [IN_W:0]    de_in  [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			s_in[a]  = in_data[a*IN_W +: IN_W];
			e_in[a]  = in_data[(a+3)*IN_W +: IN_W];
			v_in[a]  = {s_in[a][IN_W-1], s_in[a][IN_W-1:FRAC_BITS]};
			ev_in[a] = {e_in[a][IN_W-1], e_in[a][IN_W-1:FRAC_BITS]};
			fr_in[a] = s_in[a][FRAC_BITS-1:0];
			d_in[a]  = ev_in[a] - v_in[a];
			span_in[a] = d_in[a][IDX_W-1] ? SPAN_W'(-d_in[a]) : SPAN_W'(d_in[a]);
			// Moving down from an integer start waits one whole voxel.
			if (!d_in[a][IDX_W-1]) begin
				num_in[a] = ONE_VOX - NUM_W'(fr_in[a]);
			end else if (fr_in[a] == '0) begin
				num_in[a] = ONE_VOX;
			end else begin
				num_in[a] = NUM_W'(fr_in[a]);
			end
			de_in[a] = {e_in[a][IN_W-1], e_in[a]} - {s_in[a][IN_W-1], s_in[a]};
		end
	end

	// Walk state.
	logic signed [IDX_W-1:0] v_q    [3];
	logic signed [IDX_W-1:0] ev_q   [3];
	logic [FRAC_BITS-1:0]    fr_q   [3];
	logic [SPAN_W-1:0]       span_q [3];
	logic                    neg_q  [3];
	logic [NUM_W-1:0]        num0_q [3];
	logic signed [IN_W:0]    de_q   [3];
	logic signed [Q_W-1:0]   q_q    [3];
	logic [SQ_W-1:0]         qsq_q  [3];
	logic [P_W-1:0]          p_q    [3][3];
	logic [SQ_W-1:0]         len2_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    pend_valid_q;
	logic                    pend_trunc_q;
	logic [OUT_DATA_W-1:0]   pend_q;

	// Shared multiplier for setup.
	logic signed [MUL_W-1:0]   ma, mb;
	logic signed [2*MUL_W-1:0] prod;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul_sel)
			MUL_LEN_X: begin ma = MUL_W'(de_q[0]); mb = MUL_W'(de_q[0]); end
			MUL_LEN_Y: begin ma = MUL_W'(de_q[1]); mb = MUL_W'(de_q[1]); end
			MUL_LEN_Z: begin ma = MUL_W'(de_q[2]); mb = MUL_W'(de_q[2]); end
			MUL_SQ_X:  begin ma = MUL_W'({1'b0, fr_q[0]}); mb = MUL_W'({1'b0, fr_q[0]}); end
			MUL_SQ_Y:  begin ma = MUL_W'({1'b0, fr_q[1]}); mb = MUL_W'({1'b0, fr_q[1]}); end
			MUL_SQ_Z:  begin ma = MUL_W'({1'b0, fr_q[2]}); mb = MUL_W'({1'b0, fr_q[2]}); end
			MUL_P01:   begin ma = MUL_W'({1'b0, num0_q[0]}); mb = MUL_W'({1'b0, span_q[1]}); end
			MUL_P10:   begin ma = MUL_W'({1'b0, num0_q[1]}); mb = MUL_W'({1'b0, span_q[0]}); end
			MUL_P02:   begin ma = MUL_W'({1'b0, num0_q[0]}); mb = MUL_W'({1'b0, span_q[2]}); end
			MUL_P20:   begin ma = MUL_W'({1'b0, num0_q[2]}); mb = MUL_W'({1'b0, span_q[0]}); end
			MUL_P12:   begin ma = MUL_W'({1'b0, num0_q[1]}); mb = MUL_W'({1'b0, span_q[2]}); end
			MUL_P21:   begin ma = MUL_W'({1'b0, num0_q[2]}); mb = MUL_W'({1'b0, span_q[1]}); end
			default:   begin ma = '0; mb = '0; end
		endcase
		prod = ma * mb;
	end

	// Per-step decisions.
	logic            inbox, atend, dist_stop, trunc_hit, stop;
	logic [SQ_W-1:0] corner_d2;
	logic            e01, e02, e12;
	logic [1:0]      ax;

	function automatic logic earlier(input logic [SPAN_W-1:0] span_a,
	                                 input logic [SPAN_W-1:0] span_b,
	                                 input logic [P_W-1:0] p_ab,
	                                 input logic [P_W-1:0] p_ba);
		earlier = (span_a != '0) && ((span_b == '0) || (p_ab < p_ba));
	endfunction

	always_comb begin
		inbox = 1'b1;
		atend = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (v_q[a] < bmin_q[a] || v_q[a] >= bmax_q[a]) inbox = 1'b0;
			if (v_q[a] != ev_q[a]) atend = 1'b0;
		end
		corner_d2 = qsq_q[0] + qsq_q[1] + qsq_q[2];
		dist_stop = inbox && (corner_d2 > len2_q);
		trunc_hit = inbox && (cnt_q >= CNT_W'(MAX_VOXELS - 1));
		stop      = atend || dist_stop || trunc_hit;
		e01 = earlier(span_q[0], span_q[1], p_q[0][1], p_q[1][0]);
		e02 = earlier(span_q[0], span_q[2], p_q[0][2], p_q[2][0]);
		e12 = earlier(span_q[1], span_q[2], p_q[1][2], p_q[2][1]);
		// Ties go to the higher axis.
		if (e01) begin
			ax = e02 ? 2'd0 : 2'd2;
		end else begin
			ax = e12 ? 2'd1 : 2'd2;
		end
	end

	// Square update when the corner offset moves one voxel along the axis.
	logic signed [SQ_W:0] q_ext, q_dlt;
	logic [SQ_W-1:0]      qsq_nxt;

	always_comb begin
		q_ext   = (SQ_W+1)'(q_q[ax]);
		q_dlt   = neg_q[ax] ? -(q_ext <<< (FRAC_BITS + 1)) : (q_ext <<< (FRAC_BITS + 1));
		qsq_nxt = SQ_W'($signed({1'b0, qsq_q[ax]}) + q_dlt
		                + (SQ_W+1)'(2 ** (2 * FRAC_BITS)));
	end

	logic [OUT_DATA_W-1:0] vox_now;
	assign vox_now = {v_q[2][VOX_W-1:0], v_q[1][VOX_W-1:0], v_q[0][VOX_W-1:0]};

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int a = 0; a < 3; a++) begin
				v_q[a]    <= v_in[a];
				ev_q[a]   <= ev_in[a];
				fr_q[a]   <= fr_in[a];
				span_q[a] <= span_in[a];
				neg_q[a]  <= d_in[a][IDX_W-1];
				num0_q[a] <= num_in[a];
				de_q[a]   <= de_in[a];
				q_q[a]    <= -Q_W'(fr_in[a]);
				p_q[a][a] <= '0;
			end
			len2_q <= '0;
		end else if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MUL_LEN_X, MUL_LEN_Y, MUL_LEN_Z: len2_q <= len2_q + prod[SQ_W-1:0];
				MUL_SQ_X: qsq_q[0]  <= prod[SQ_W-1:0];
				MUL_SQ_Y: qsq_q[1]  <= prod[SQ_W-1:0];
				MUL_SQ_Z: qsq_q[2]  <= prod[SQ_W-1:0];
				MUL_P01:  p_q[0][1] <= prod[P_W-1:0];
				MUL_P10:  p_q[1][0] <= prod[P_W-1:0];
				MUL_P02:  p_q[0][2] <= prod[P_W-1:0];
				MUL_P20:  p_q[2][0] <= prod[P_W-1:0];
				MUL_P12:  p_q[1][2] <= prod[P_W-1:0];
				MUL_P21:  p_q[2][1] <= prod[P_W-1:0];
				default: ;
			endcase
		end else if (cmd.walk) begin
			if (inbox) begin
				pend_q       <= vox_now;
				pend_trunc_q <= trunc_hit && !atend && !dist_stop;
			end
			if (!stop) begin
				v_q[ax]   <= neg_q[ax] ? v_q[ax] - 1'b1 : v_q[ax] + 1'b1;
				q_q[ax]   <= neg_q[ax] ? q_q[ax] - Q_W'(ONE_VOX) : q_q[ax] + Q_W'(ONE_VOX);
				qsq_q[ax] <= qsq_nxt;
				// The stepped axis' crossing moves one voxel later in time.
				for (int b = 0; b < 3; b++) begin
					if (b != int'(ax)) begin
						p_q[ax][b] <= p_q[ax][b] + (P_W'(span_q[b]) << FRAC_BITS);
					end
				end
			end
		end
	end

	// Count of emitted voxels and the held-back voxel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.walk && inbox) begin
			cnt_q        <= cnt_q + 1'b1;
			pend_valid_q <= 1'b1;
		end
	end

	// Output register. A voxel is held until the next one shows whether it ends the ray.
	logic out_load;
	assign out_load = (cmd.walk && inbox && pend_valid_q) || cmd.finish;

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd.finish) begin
				out_data <= pend_valid_q ? pend_q : '0;
				out_user <= {pend_valid_q && pend_trunc_q, pend_valid_q};
				out_last <= 1'b1;
			end else begin
				out_data <= pend_q;
				out_user <= 2'b01;
				out_last <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_comb begin
		stat.degenerate = (span_q[0] == '0) && (span_q[1] == '0) && (span_q[2] == '0);
		stat.inbox      = inbox;
		stat.stop       = stop;
		stat.out_free   = !out_valid || out_ready;
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk && inbox) |-> (cnt_q < CNT_W'(MAX_VOXELS)))
		else $error("voxel emitted beyond the limit");
	a_capture_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (cnt_q == '0 && !pend_valid_q))
		else $error("new ray did not clear the emit count");
`endif

endmodule
